// ===== hdl/lphh_pkg.sv =====
// Shared types, constants and helper functions of the line hash unit.
`default_nettype none

package lphh_pkg;

   localparam logic [7:0]  NEWLINE_CHAR = 8'h0a;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;   // '0'
   localparam logic [7:0]  CHAR_A_TEN   = 8'h57;   // 'a' - 10
   localparam logic [8:0]  OFFSET_BIAS  = 9'd96;   // 'a' - 1
   localparam logic [4:0]  HASH_BASE    = 5'd31;

   localparam logic [29:0] HASH_MOD     = 30'd1000000009;
   localparam logic [31:0] MOD_X1       = 32'd1000000009;
   localparam logic [31:0] MOD_X2       = 32'd2000000018;
   localparam logic [31:0] MOD_X3       = 32'd3000000027;
   // 2^30 mod the modulus: folds bits above 30 back into range
   localparam logic [26:0] FOLD_C       = 27'd73741815;
   // 96 * modulus, lifts (b - 96) * p to a non-negative value
   localparam logic [39:0] BIAS_MOD     = 40'd96000000864;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   typedef struct packed {
      logic [29:0] hash;
      logic [2:0]  top;    // index of highest non-zero hex digit
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIGIT,
      BK_NEWLINE
   } back_state_type;

   // value below 4 * modulus -> residue
   function automatic logic [29:0] reduce4(input logic [31:0] w);
      logic [31:0] r;
      r = w;
      if (w >= MOD_X3) begin
         r = w - MOD_X3;
      end else if (w >= MOD_X2) begin
         r = w - MOD_X2;
      end else if (w >= MOD_X1) begin
         r = w - MOD_X1;
      end
      return r[29:0];
   endfunction

   function automatic logic [2:0] top_digit(input logic [29:0] h);
      logic [31:0] w;
      logic [2:0]  t;
      w = {2'b00, h};
      t = '0;
      for (int i = 1; i < 8; i++) begin
         if (w[i*4 +: 4] != 4'd0) begin
            t = 3'(i);
         end
      end
      return t;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + 8'(d);
      end else begin
         c = CHAR_A_TEN + 8'(d);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/lphh_front.sv =====
// Front end: byte intake, power update, term pipeline and hash accumulator.
`default_nettype none

module lphh_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_in_byte,
   input  wire lphh_pkg::qstat_type  q_stat,
   output logic                      push,
   output lphh_pkg::entry_type       push_entry
);

   logic               adv;
   logic               accept;
   logic               is_nl;

   logic [29:0]        p_ff, p_in;
   logic [29:0]        h_ff, h_in;

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic               s1_nl_ff, s2_nl_ff, s3_nl_ff;
   logic signed [39:0] s1_prod_ff, s1_prod_in;
   logic [34:0]        s2_y_ff, s2_y_in;
   logic [29:0]        s3_term_ff, s3_term_in;

   logic signed [8:0]  off;
   logic signed [30:0] p_s;
   logic [39:0]        x_full;
   logic [34:0]        p31;
   logic [31:0]        p_fold;
   logic [31:0]        z;
   logic [30:0]        acc_sum;

   // whole pipe holds only while a finished hash waits for queue space
   assign adv       = !(s3_valid_ff && s3_nl_ff && q_stat.full);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign is_nl     = (req_in_byte == lphh_pkg::NEWLINE_CHAR);

   // stage 1: signed offset times power
   assign off        = $signed({1'b0, req_in_byte}) - $signed(lphh_pkg::OFFSET_BIAS);
   assign p_s        = $signed({1'b0, p_ff});
   assign s1_prod_in = off * p_s;

   // power: p * 31 folded at bit 30, then final reduce
   assign p31    = 35'(p_ff) * 35'(lphh_pkg::HASH_BASE);
   assign p_fold = 32'(p31[29:0]) + 32'(p31[34:30]) * 32'(lphh_pkg::FOLD_C);

   always_comb begin
      p_in = p_ff;
      if (accept) begin
         if (is_nl) begin
            p_in = 30'd1;
         end else begin
            p_in = lphh_pkg::reduce4(p_fold);
         end
      end
   end

   // stage 2: bias to non-negative, first fold
   assign x_full  = 40'(s1_prod_ff) + lphh_pkg::BIAS_MOD;
   assign s2_y_in = 35'(x_full[29:0]) + 35'(x_full[37:30]) * 35'(lphh_pkg::FOLD_C);

   // stage 3: second fold, below 3 * modulus
   assign z          = 32'(s2_y_ff[29:0]) + 32'(s2_y_ff[34:30]) * 32'(lphh_pkg::FOLD_C);
   assign s3_term_in = lphh_pkg::reduce4(z);

   // accumulator
   assign acc_sum = 31'(h_ff) + 31'(s3_term_ff);
   assign push    = adv && s3_valid_ff && s3_nl_ff;

   always_comb begin
      h_in = h_ff;
      if (adv && s3_valid_ff) begin
         if (s3_nl_ff) begin
            h_in = '0;
         end else if (acc_sum >= 31'(lphh_pkg::HASH_MOD)) begin
            h_in = 30'(acc_sum - 31'(lphh_pkg::HASH_MOD));
         end else begin
            h_in = acc_sum[29:0];
         end
      end
   end

   assign push_entry.hash = h_ff;
   assign push_entry.top  = lphh_pkg::top_digit(h_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff        <= 30'd1;
         h_ff        <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         p_ff <= p_in;
         h_ff <= h_in;
         if (adv) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_nl_ff   <= is_nl;
         s1_prod_ff <= s1_prod_in;
         s2_nl_ff   <= s1_nl_ff;
         s2_y_ff    <= s2_y_in;
         s3_nl_ff   <= s2_nl_ff;
         s3_term_ff <= s3_term_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lphh_queue.sv =====
// Small FIFO of finished line hashes between front and back end.
`default_nettype none

module lphh_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lphh_pkg::entry_type  push_entry,
   input  wire logic                 pop,
   output lphh_pkg::entry_type       pop_entry,
   output lphh_pkg::qstat_type       q_stat
);

   lphh_pkg::entry_type              mem_ff [lphh_pkg::Q_DEPTH];
   logic [lphh_pkg::Q_AW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [lphh_pkg::Q_AW:0]          count_ff, count_in;

   assign q_stat.full  = (count_ff == (lphh_pkg::Q_AW+1)'(lphh_pkg::Q_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_entry    = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lphh_back.sv =====
// Back end: turns each queued hash into hex characters and a closing newline.
`default_nettype none

module lphh_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lphh_pkg::qstat_type  q_stat,
   input  wire lphh_pkg::entry_type  pop_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_out_char,
   output logic                      rsp_out_last
);

   lphh_pkg::back_state_type state_ff, state_in;

   logic [29:0] hash_ff;
   logic [2:0]  idx_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff;
   logic        rsp_last_ff;

   logic        load;
   logic        emit;
   logic [7:0]  emit_char;
   logic        emit_last;
   logic [31:0] hash_w;
   logic [3:0]  nibble;

   assign load   = !rsp_valid_ff || !rsp_stall;
   assign hash_w = {2'b00, hash_ff};
   assign nibble = hash_w[{idx_ff, 2'b00} +: 4];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lphh_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               state_in = lphh_pkg::BK_DIGIT;
            end
         end
         lphh_pkg::BK_DIGIT: begin
            if (load && idx_ff == 3'd0) begin
               state_in = lphh_pkg::BK_NEWLINE;
            end
         end
         lphh_pkg::BK_NEWLINE: begin
            if (load) begin
               state_in = q_stat.empty ? lphh_pkg::BK_IDLE : lphh_pkg::BK_DIGIT;
            end
         end
         default: begin
            state_in = lphh_pkg::BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      emit_char = lphh_pkg::NEWLINE_CHAR;
      emit_last = 1'b0;
      case (state_ff)
         lphh_pkg::BK_IDLE: begin
            pop = !q_stat.empty;
         end
         lphh_pkg::BK_DIGIT: begin
            emit      = load;
            emit_char = lphh_pkg::hex_char(nibble);
         end
         lphh_pkg::BK_NEWLINE: begin
            emit      = load;
            emit_last = 1'b1;
            pop       = load && !q_stat.empty;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = load ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lphh_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         hash_ff <= pop_entry.hash;
         idx_ff  <= pop_entry.top;
      end else if (state_ff == lphh_pkg::BK_DIGIT && load) begin
         idx_ff  <= idx_ff - 1'b1;
      end
      if (emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/line_polynomial_hash_hex_unit.sv =====
// Top level of the line hash unit: front end, hash queue and hex formatter.
`default_nettype none

// Line hash unit. Takes a byte stream, one byte per transaction, and keeps a
// polynomial rolling hash of the current line modulo 1000000009: every byte b
// other than newline adds (b - 96) * p, where p = 31^k for the k-th byte of the
// line; bytes below 96 give a negative offset that is reduced properly. A
// newline byte closes the line and produces a reply of lowercase hex digits
// without leading zeros ("0" for an empty or zero-hash line), followed by a
// newline transaction with rsp_out_last high; the hash and power then restart.
// Rate: one input byte per clock while req_stall is low. A byte's term passes
// a three-stage multiply-and-fold pipeline before reaching the accumulator; a
// line's hash enters the queue once its newline leaves the third stage, and its
// first character then passes the queue, the formatter's hash load and the
// output register. Replies leave at one character per clock while rsp_stall is
// low, digits then newline. A four-entry hash queue sits between accumulator and
// formatter, and req_stall rises only when that queue is full with a finished
// hash waiting, i.e. in long runs of very short lines or a stalled result side.
module line_polynomial_hash_hex_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_out_last
);

   lphh_pkg::qstat_type q_stat;
   lphh_pkg::entry_type push_entry;
   lphh_pkg::entry_type pop_entry;
   logic                push;
   logic                pop;

   // accumulates hashes, hands a finished line hash to the queue
   lphh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_stat      (q_stat),
      .push        (push),
      .push_entry  (push_entry)
   );

   lphh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_stat     (q_stat)
   );

   // formats one hash at a time, one character per transaction
   lphh_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire
